@@ rtl/core/aaod_pkg.sv @@
// Package for the accessory address output decoder.
// Holds item kinds, register indexes, the item carried along the cell chain
// and the per-pin mode bits. No dependencies.
package aaod_pkg;

	localparam int PIN_COUNT = 16;
	localparam int PIN_W     = 4;
	localparam int STAT_W    = 16;
	localparam int ADDR_W    = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		KIND_SENSOR  = 2'd0,
		KIND_REQUEST = 2'd1,
		KIND_REPORT  = 2'd2,
		KIND_LOAD    = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIN_IS_OUTPUT  = 3'd0,
		REG_PIN_IS_SENSOR  = 3'd1,
		REG_PIN_IS_REPORT  = 3'd2,
		REG_PIN_INVERTED   = 3'd3,
		REG_STATUS_REQ_ADR = 3'd4
	} reg_idx_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] bus_address;
		logic              direction_bit;
		logic              output_bit;
		logic [PIN_W-1:0]  pin_index;
		logic              status_request;
		logic [STAT_W-1:0] output_status;
	} item_t;

	typedef struct packed {
		logic is_output;
		logic is_sensor;
		logic is_report;
		logic inverted;
	} pin_cfg_t;

endpackage

@@ rtl/core/aaod_cell.sv @@
// One pin cell of the accessory address output decoder chain.
// Holds the pin's table address and output bit, updates them as an item
// passes, and hands the item on to the next cell. Depends on aaod_pkg.
module aaod_cell import aaod_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [PIN_W-1:0] idx,
	input  pin_cfg_t         pin_cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_t            in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output item_t            out_item
);

	logic [ADDR_W-1:0] pin_addr_q;
	logic              bit_q;
	logic              valid_q;
	item_t             item_q;

	logic  in_fire;
	logic  mode_hit;
	logic  info;
	logic  upd;
	logic  bit_nxt;
	logic  load;
	item_t item_nxt;

	assign in_ready = !valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		mode_hit = 1'b0;
		info     = in_item.direction_bit;
		priority if (pin_cfg.is_sensor) begin
			mode_hit = (in_item.kind == KIND_SENSOR);
		end else if (pin_cfg.is_report) begin
			mode_hit = (in_item.kind == KIND_REPORT);
			info     = idx[0] ? in_item.direction_bit : in_item.output_bit;
		end else begin
			mode_hit = (in_item.kind == KIND_REQUEST);
		end
	end

	assign load = (in_item.kind == KIND_LOAD) && (in_item.pin_index == idx);
	assign upd  = pin_cfg.is_output && mode_hit && !in_item.status_request
		&& (pin_addr_q != '0) && (pin_addr_q == in_item.bus_address);
	assign bit_nxt = upd ? (info ^ pin_cfg.inverted) : bit_q;

	always_comb begin
		item_nxt                    = in_item;
		item_nxt.output_status[idx] = bit_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_addr_q <= '0;
			bit_q      <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (in_fire) begin
				bit_q <= bit_nxt;
				if (load) begin
					pin_addr_q <= in_item.bus_address;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= item_nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

`ifndef SYNTHESIS
	a_load_keeps_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_item.kind == KIND_LOAD) |=> $stable(bit_q))
		else $error("load item changed pin output bit");

	a_req_keeps_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_item.status_request) |=> $stable(bit_q))
		else $error("status request item changed pin output bit");

	a_bit_handed_on: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (item_q.output_status[idx] == bit_q))
		else $error("item carries wrong pin bit");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(item_q)))
		else $error("stalled item lost or changed");
`endif

endmodule

@@ rtl/core/accessory_address_output_decoder.sv @@
// Top level of the accessory address output decoder.
// Holds the configuration registers and the chain of pin cells.
// Depends on aaod_pkg and aaod_cell.

// Each item runs through a chain of PIN_COUNT pin cells, one register stage
// per cell; the chain takes one item per cycle while out_stall is low, and
// every cell can hold an item while the output side stalls. Each cell keeps
// its pin's table address and output bit and updates them as the item
// passes, so the result carries the output status after that item. Each
// cell reads its pin's mode bits as the item passes, so write configuration
// only while no item is in flight.
module accessory_address_output_decoder import aaod_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic [ADDR_W-1:0]    bus_address,
	input  logic                 direction_bit,
	input  logic                 output_bit,
	input  logic [PIN_W-1:0]     pin_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STAT_W-1:0]    output_status,
	output logic                 status_request
);

	logic [STAT_W-1:0] pin_is_output_q;
	logic [STAT_W-1:0] pin_is_sensor_q;
	logic [STAT_W-1:0] pin_is_report_q;
	logic [STAT_W-1:0] pin_inverted_q;
	logic [ADDR_W-1:0] status_req_adr_q;

	item_t stage [0:PIN_COUNT];
	logic  vld   [0:PIN_COUNT];
	logic  rdy   [0:PIN_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_is_output_q  <= '0;
			pin_is_sensor_q  <= '0;
			pin_is_report_q  <= '0;
			pin_inverted_q   <= '0;
			status_req_adr_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PIN_IS_OUTPUT:  pin_is_output_q  <= cfg_data;
				REG_PIN_IS_SENSOR:  pin_is_sensor_q  <= cfg_data;
				REG_PIN_IS_REPORT:  pin_is_report_q  <= cfg_data;
				REG_PIN_INVERTED:   pin_inverted_q   <= cfg_data;
				REG_STATUS_REQ_ADR: status_req_adr_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		stage[0].kind           = kind_t'(kind);
		stage[0].bus_address    = bus_address;
		stage[0].direction_bit  = direction_bit;
		stage[0].output_bit     = output_bit;
		stage[0].pin_index      = pin_index;
		stage[0].status_request = (kind_t'(kind) != KIND_LOAD)
			&& (bus_address == status_req_adr_q);
		stage[0].output_status  = '0;
	end

	assign vld[0]         = in_valid;
	assign in_stall       = !rdy[0];
	assign rdy[PIN_COUNT] = !out_stall;

	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_cell
		pin_cfg_t cfg;

		assign cfg.is_output = pin_is_output_q[g];
		assign cfg.is_sensor = pin_is_sensor_q[g];
		assign cfg.is_report = pin_is_report_q[g];
		assign cfg.inverted  = pin_inverted_q[g];

		aaod_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (PIN_W'(g)),
			.pin_cfg   (cfg),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_item   (stage[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_item  (stage[g+1])
		);
	end

	assign out_valid      = vld[PIN_COUNT];
	assign output_status  = stage[PIN_COUNT].output_status;
	assign status_request = stage[PIN_COUNT].status_request;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the accessory address output decoder: directed table, then random phases.
// Predicts output status and status requests per item and checks every result in order.
// Depends on aaod_pkg and accessory_address_output_decoder from the RTL.
module tb_top;
	import aaod_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int PHASES       = 6;

	typedef struct {
		kind_t             op;
		logic [ADDR_W-1:0] adr;
		logic              dir;
		logic              outb;
		logic [PIN_W-1:0]  pin;
		bit                typed;
		logic [STAT_W-1:0] want_status;
		logic              want_req;
	} notice_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              req;
	} status_word_t;

	typedef struct {
		logic [STAT_W-1:0] out_mask;
		logic [STAT_W-1:0] sensor_mask;
		logic [STAT_W-1:0] report_mask;
		logic [STAT_W-1:0] invert_mask;
		logic [ADDR_W-1:0] req_adr;
	} setup_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           kind;
	logic [ADDR_W-1:0]    bus_address;
	logic                 direction_bit;
	logic                 output_bit;
	logic [PIN_W-1:0]     pin_index;
	logic                 out_valid;
	logic                 out_stall;
	logic [STAT_W-1:0]    output_status;
	logic                 status_request;

	setup_t            cur_setup;
	logic [ADDR_W-1:0] pin_adr [PIN_COUNT];
	logic [STAT_W-1:0] pin_state;
	logic [ADDR_W-1:0] addr_pool [8];
	status_word_t      status_q [$];

	int errors;
	int checked;
	int requests_seen;
	int directed_sent;
	int random_sent;
	int setups;
	int gap_pct;
	int stall_pct;
	int stall_left;
	int cycles;

	notice_t reset_rows [4] = '{
		'{KIND_SENSOR,  12'h000, 1'b1, 1'b1, 4'h0, 1'b1, 16'h0000, 1'b1},
		'{KIND_REQUEST, 12'hFFF, 1'b1, 1'b1, 4'hF, 1'b1, 16'h0000, 1'b0},
		'{KIND_LOAD,    12'hFFF, 1'b1, 1'b1, 4'hF, 1'b1, 16'h0000, 1'b0},
		'{KIND_REPORT,  12'h000, 1'b0, 1'b0, 4'h0, 1'b1, 16'h0000, 1'b1}
	};

	// pins 0-3 sensor, 4-7 report, 8-15 request; pins 1, 3, 9, 11 inverted
	notice_t pin_rows [21] = '{
		'{KIND_LOAD,    12'h001, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'h001, 1'b0, 1'b0, 4'h1, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'h123, 1'b0, 1'b0, 4'h4, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'h123, 1'b0, 1'b0, 4'h5, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'h800, 1'b0, 1'b0, 4'h9, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'h7FF, 1'b0, 1'b0, 4'hF, 1'b0, 16'h0, 1'b0},
		'{KIND_SENSOR,  12'h001, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REQUEST, 12'h001, 1'b0, 1'b1, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REPORT,  12'h123, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REPORT,  12'h123, 1'b0, 1'b1, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_SENSOR,  12'h123, 1'b1, 1'b1, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REQUEST, 12'h800, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REQUEST, 12'h800, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REQUEST, 12'h7FF, 1'b1, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_SENSOR,  12'hFFF, 1'b1, 1'b1, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'hFFF, 1'b0, 1'b0, 4'h3, 1'b0, 16'h0, 1'b0},
		'{KIND_SENSOR,  12'hFFF, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_LOAD,    12'h000, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_SENSOR,  12'h000, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_SENSOR,  12'h001, 1'b0, 1'b0, 4'h0, 1'b0, 16'h0, 1'b0},
		'{KIND_REPORT,  12'h123, 1'b1, 1'b1, 4'h0, 1'b0, 16'h0, 1'b0}
	};

	accessory_address_output_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.bus_address    (bus_address),
		.direction_bit  (direction_bit),
		.output_bit     (output_bit),
		.pin_index      (pin_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.output_status  (output_status),
		.status_request (status_request)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic status_word_t decode_notification(notice_t n);
		status_word_t r;
		logic         info;
		logic         hit;
		r.req = 1'b0;
		if (n.op == KIND_LOAD) begin
			pin_adr[n.pin] = n.adr;
		end else if (n.adr == cur_setup.req_adr) begin
			r.req = 1'b1;
		end else begin
			for (int i = 0; i < PIN_COUNT; i++) begin
				info = n.dir;
				if (!cur_setup.out_mask[i] || pin_adr[i] == '0 || pin_adr[i] != n.adr)
					continue;
				if (cur_setup.sensor_mask[i])
					hit = (n.op == KIND_SENSOR);
				else if (cur_setup.report_mask[i]) begin
					hit = (n.op == KIND_REPORT);
					if (i % 2 == 0)
						info = n.outb;
				end else
					hit = (n.op == KIND_REQUEST);
				if (hit)
					pin_state[i] = info ^ cur_setup.invert_mask[i];
			end
		end
		r.status = pin_state;
		return r;
	endfunction

	function automatic notice_t random_notice();
		notice_t n;
		int      sel;
		sel = $urandom_range(0, 99);
		n.typed = 1'b0;
		n.want_status = '0;
		n.want_req = 1'b0;
		n.dir = 1'($urandom_range(0, 1));
		n.outb = 1'($urandom_range(0, 1));
		n.pin = PIN_W'($urandom_range(0, PIN_COUNT - 1));
		if (sel < 25) begin
			n.op = KIND_LOAD;
			if (sel < 3)
				n.adr = ADDR_W'($urandom_range(0, 4095));
			else if (sel < 5)
				n.adr = '0;
			else
				n.adr = addr_pool[$urandom_range(0, 7)];
		end else begin
			n.op = kind_t'($urandom_range(0, 2));
			if (sel < 32)
				n.adr = cur_setup.req_adr;
			else if (sel < 40)
				n.adr = ADDR_W'($urandom_range(0, 4095));
			else
				n.adr = addr_pool[$urandom_range(0, 7)];
		end
		return n;
	endfunction

	task automatic take_result();
		status_word_t want;
		if (status_q.size() == 0) begin
			$error("result with no item pending: output_status %h", output_status);
			errors++;
		end else begin
			want = status_q.pop_front();
			checked++;
			if (want.req)
				requests_seen++;
			if (output_status !== want.status) begin
				$error("output_status: expected %h, got %h", want.status, output_status);
				errors++;
			end
			if (status_request !== want.req) begin
				$error("status_request: expected %b, got %b", want.req, status_request);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			take_result();
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	task automatic send_notice(notice_t n);
		status_word_t prd;
		in_valid <= 1'b1;
		kind <= n.op;
		bus_address <= n.adr;
		direction_bit <= n.dir;
		output_bit <= n.outb;
		pin_index <= n.pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		prd = decode_notification(n);
		if (n.typed) begin
			prd.status = n.want_status;
			prd.req = n.want_req;
		end
		status_q.push_back(prd);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_setup(setup_t s);
		cur_setup = s;
		write_reg(REG_PIN_IS_OUTPUT, s.out_mask);
		write_reg(REG_PIN_IS_SENSOR, s.sensor_mask);
		write_reg(REG_PIN_IS_REPORT, s.report_mask);
		write_reg(REG_PIN_INVERTED, s.invert_mask);
		write_reg(REG_STATUS_REQ_ADR, {{(CFG_W - ADDR_W){1'b0}}, s.req_adr});
		cfg_wr_en <= 1'b0;
		setups++;
	endtask

	initial begin
		setup_t s;
		int     wait_cycles;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_PIN_IS_OUTPUT;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_SENSOR;
		bus_address = '0;
		direction_bit = 1'b0;
		output_bit = 1'b0;
		pin_index = '0;
		out_stall = 1'b0;
		cur_setup = '{default: '0};
		foreach (pin_adr[i])
			pin_adr[i] = '0;
		pin_state = '0;
		gap_pct = 15;
		stall_pct = 15;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_rows[i]) begin
			send_notice(reset_rows[i]);
			directed_sent++;
		end
		in_valid <= 1'b0;
		drain_results();
		apply_setup('{16'hFFFF, 16'h000F, 16'h00F0, 16'h0A0A, 12'hFFF});
		foreach (pin_rows[i]) begin
			send_notice(pin_rows[i]);
			directed_sent++;
		end
		in_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF};
				1: s = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 12'h000};
				2: s = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom), 12'($urandom)};
				default: begin
					s.out_mask = 16'($urandom | $urandom);
					s.sensor_mask = 16'($urandom);
					s.report_mask = 16'($urandom);
					s.invert_mask = 16'($urandom);
					s.req_adr = 12'($urandom);
				end
			endcase
			case (ph)
				0: begin gap_pct = 10; stall_pct = 10; end
				1: begin gap_pct = 30; stall_pct = 30; end
				2: begin gap_pct = 0;  stall_pct = 50; end
				3: begin gap_pct = 50; stall_pct = 0;  end
				4: begin gap_pct = 20; stall_pct = 20; end
				default: begin gap_pct = 0; stall_pct = 0; end
			endcase
			addr_pool[0] = 12'hFFF;
			addr_pool[1] = 12'h001;
			for (int k = 2; k < 8; k++)
				addr_pool[k] = ADDR_W'($urandom_range(1, 4095));
			apply_setup(s);
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				send_notice(random_notice());
				random_sent++;
			end
			in_valid <= 1'b0;
		end

		wait_cycles = 0;
		while (status_q.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (2 * PIN_COUNT + 8)
			@(posedge clk);
		if (status_q.size() != 0) begin
			$error("%0d expected results never arrived", status_q.size());
			errors++;
		end
		$display("Sent %0d table items and %0d random items across %0d register setups.",
			directed_sent, random_sent, setups);
		$display("Checked %0d results, %0d of them status requests; %0d mismatches.",
			checked, requests_seen, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
